/* hw/rtl/iorob_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iorob_pkg
// Types and constants shared by the in-order reorder buffer.
// ----------------------------------------------------------------------------
package iorob_pkg;

	localparam int OP_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_MARK   = 2'd1,
		OP_COMMIT = 2'd2
	} op_t;

endpackage
`default_nettype wire

/* hw/rtl/in_order_reorder_buffer_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// in_order_reorder_buffer_core
// Circular in-order reorder buffer with allocate, mark-executed and commit.
// ----------------------------------------------------------------------------
// Each request arrives on the slave stream: tuser carries the operation and
// tdata carries the old physical register, its valid flag and the entry
// index. Each request yields exactly one response on the master stream with
// the allocated index, reject flag, freed register, commit flag and the
// occupancy, full and empty status after the request.
// Head, tail, count and the executed marks live in flip-flops; the old
// register and its valid flag live in a synchronous memory, read at the
// head when a request is taken.
// A response passes through the memory read into the stage ahead of the
// output register, then the output register. One request is taken every
// cycle while the receiver keeps up; the single read port of the memory
// feeds a one-entry stage ahead of the output register.
// When the receiver stalls, the output register and the stage before it
// fill and s_tready falls; nothing is lost or repeated.
// Reset empties the buffer and clears all executed marks; the memory is not
// cleared, since no live entry is ever read before it is written.
// ----------------------------------------------------------------------------
module in_order_reorder_buffer_core
	import iorob_pkg::*;
#(
	parameter int ROB_DEPTH = 16,
	parameter int PHYS_REGS = 64,
	localparam int IDX_W = $clog2(ROB_DEPTH),
	localparam int CNT_W = $clog2(ROB_DEPTH + 1),
	localparam int REG_W = $clog2(PHYS_REGS),
	localparam int IN_W = REG_W + 1 + IDX_W,
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W = IDX_W + 3 + REG_W + CNT_W + 2,
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// old_phys_reg, old_reg_valid, entry_index
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// op
	input  wire logic [OP_W-1:0]        s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// alloc_index, alloc_rejected, freed_valid, freed_reg, committed,
	// occupancy, is_full, is_empty
	output logic [OUT_TDATA_W-1:0]      m_tdata
);

	logic [REG_W-1:0] in_reg;
	logic             in_rvalid;
	logic [IDX_W-1:0] in_idx;
	op_t              op;
	logic             in_fire;
	logic             alloc_ok;
	logic             alloc_rej;
	logic             mark_ok;
	logic             commit_ok;
	logic [CNT_W-1:0] count_next;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;

	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [ROB_DEPTH-1:0] exec_q;
	logic [REG_W:0]    rob_mem_q [ROB_DEPTH];

	logic             valid_s1;
	logic [IDX_W-1:0] alloc_idx_s1;
	logic             rej_s1;
	logic             commit_s1;
	logic [CNT_W-1:0] count_s1;
	logic [REG_W:0]   rd_s1;
	logic             s1_move;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             freed_valid;
	logic [REG_W-1:0] freed_reg;
	logic [OUT_W-1:0] out_word;

	assign in_reg    = s_tdata[REG_W-1:0];
	assign in_rvalid = s_tdata[REG_W];
	assign in_idx    = s_tdata[REG_W+1 +: IDX_W];
	assign op        = op_t'(s_tuser);

	assign s1_move  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_move;
	assign in_fire  = s_tvalid && s_tready;

	always_comb begin
		alloc_ok  = 1'b0;
		alloc_rej = 1'b0;
		mark_ok   = 1'b0;
		commit_ok = 1'b0;
		case (op)
			OP_ALLOC: begin
				alloc_ok  = (count_q != CNT_W'(ROB_DEPTH));
				alloc_rej = (count_q == CNT_W'(ROB_DEPTH));
			end
			OP_MARK: begin
				mark_ok = ({1'b0, in_idx} < (IDX_W + 1)'(ROB_DEPTH));
			end
			OP_COMMIT: begin
				commit_ok = (count_q != '0) && exec_q[head_q];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (alloc_ok) begin
			count_next = count_q + CNT_W'(1);
		end else if (commit_ok) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign head_next = (head_q == IDX_W'(ROB_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign tail_next = (tail_q == IDX_W'(ROB_DEPTH - 1)) ? '0 : tail_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			exec_q  <= '0;
		end else if (in_fire) begin
			count_q <= count_next;
			if (alloc_ok) begin
				tail_q         <= tail_next;
				exec_q[tail_q] <= 1'b0;
			end
			if (mark_ok) begin
				exec_q[in_idx] <= 1'b1;
			end
			if (commit_ok) begin
				head_q <= head_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && alloc_ok) begin
			rob_mem_q[tail_q] <= {in_rvalid, in_reg};
		end
		if (in_fire) begin
			rd_s1 <= rob_mem_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			alloc_idx_s1 <= alloc_ok ? tail_q : '0;
			rej_s1       <= alloc_rej;
			commit_s1    <= commit_ok;
			count_s1     <= count_next;
		end
		if (s1_move) begin
			out_data_q <= out_word;
		end
	end

	assign freed_valid = commit_s1 && rd_s1[REG_W];
	assign freed_reg   = freed_valid ? rd_s1[REG_W-1:0] : '0;
	assign out_word    = {(count_s1 == '0), (count_s1 == CNT_W'(ROB_DEPTH)), count_s1,
		commit_s1, freed_reg, freed_valid, rej_s1, alloc_idx_s1};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_data_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ROB_DEPTH))
		else $error("live count exceeds buffer depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(ROB_DEPTH)) |-> head_q == tail_q)
		else $error("head and tail disagree with empty or full count");

	a_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && commit_ok) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("commit did not retire exactly one entry");

	a_commit_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && commit_ok) |-> (exec_q[head_q] && count_q != '0))
		else $error("commit of a head entry that is not executed");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rej_s1) |-> (alloc_idx_s1 == '0 && !commit_s1))
		else $error("rejected allocate carries an index or a commit");

endmodule
`default_nettype wire

/* verif/in_order_reorder_buffer_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_reorder_buffer_core_test
// Self-checking testbench for the in-order reorder buffer core.
// ----------------------------------------------------------------------------
// Requests go in on the slave stream, and responses are taken from the master
// stream. Both sides insert random idle cycles. A scoreboard keeps its own
// copy of the buffer state. For every accepted request it works out the
// response that should come back, and it checks each response field by field
// against the oldest prediction. A short directed sequence covers the corner
// cases. Random traffic follows, in fill, drain and balanced phases. Mark
// indexes mostly point at live entries, so commits retire often.
// ----------------------------------------------------------------------------
module in_order_reorder_buffer_core_test;
	import iorob_pkg::*;

	localparam int ROB_DEPTH = 16;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 24;
	localparam int RANDOM_BLOCKS = 17;
	localparam int BLOCK_LEN = 100;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [3:0] entry_index;
		logic       old_reg_valid;
		logic [5:0] old_phys_reg;
	} rob_request_t;

	typedef struct packed {
		logic       is_empty;
		logic       is_full;
		logic [4:0] occupancy;
		logic       committed;
		logic [5:0] freed_reg;
		logic       freed_valid;
		logic       alloc_rejected;
		logic [3:0] alloc_index;
	} rob_result_t;

	class rob_scoreboard;
		logic [5:0]     old_regs [ROB_DEPTH];
		bit             free_flags [ROB_DEPTH];
		bit             executed [ROB_DEPTH];
		int unsigned    head;
		int unsigned    tail;
		int unsigned    live;
		rob_result_t    expected_q [$];
		int unsigned    errors;
		int unsigned    requests;
		int unsigned    commits;
		int unsigned    frees;
		int unsigned    rejects;

		function new();
			foreach (executed[i]) begin
				executed[i] = 1'b0;
				free_flags[i] = 1'b0;
				old_regs[i] = '0;
			end
			head = 0;
			tail = 0;
			live = 0;
			errors = 0;
			requests = 0;
			commits = 0;
			frees = 0;
			rejects = 0;
		endfunction

		function void note_request(logic [OP_W-1:0] op, rob_request_t req);
			rob_result_t res;
			res = '0;
			requests++;
			case (op)
			OP_ALLOC: begin
				if (live >= ROB_DEPTH) begin
					res.alloc_rejected = 1'b1;
					rejects++;
				end else begin
					old_regs[tail] = req.old_phys_reg;
					free_flags[tail] = req.old_reg_valid;
					executed[tail] = 1'b0;
					res.alloc_index = 4'(tail);
					tail = (tail + 1) % ROB_DEPTH;
					live++;
				end
			end
			OP_MARK: begin
				if (req.entry_index < ROB_DEPTH)
					executed[req.entry_index] = 1'b1;
			end
			OP_COMMIT: begin
				if (live != 0 && executed[head]) begin
					res.committed = 1'b1;
					commits++;
					if (free_flags[head]) begin
						res.freed_valid = 1'b1;
						res.freed_reg = old_regs[head];
						frees++;
					end
					head = (head + 1) % ROB_DEPTH;
					live--;
				end
			end
			default: ;
			endcase
			res.occupancy = 5'(live);
			res.is_full = (live == ROB_DEPTH);
			res.is_empty = (live == 0);
			expected_q.insert(expected_q.size(), res);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(logic [OUT_TDATA_W-1:0] data);
			rob_result_t got;
			rob_result_t want;
			got = data[$bits(rob_result_t)-1:0];
			if (expected_q.size() == 0) begin
				$error("response with no request outstanding: %h", data);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			check_field("alloc_index", want.alloc_index, got.alloc_index);
			check_field("alloc_rejected", want.alloc_rejected, got.alloc_rejected);
			check_field("freed_valid", want.freed_valid, got.freed_valid);
			check_field("freed_reg", want.freed_reg, got.freed_reg);
			check_field("committed", want.committed, got.committed);
			check_field("occupancy", want.occupancy, got.occupancy);
			check_field("is_full", want.is_full, got.is_full);
			check_field("is_empty", want.is_empty, got.is_empty);
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]        s_tuser = OP_ALLOC;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	bit                     steady = 1'b0;
	int unsigned            cycles = 0;
	rob_scoreboard          sb = new();

	in_order_reorder_buffer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("in_order_reorder_buffer_core_test: errors");
			$finish;
		end
	end

	initial begin : response_sink
		int unsigned stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_response(m_tdata);
		end
	end

	task automatic send_request(logic [OP_W-1:0] op, rob_request_t req);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_TDATA_W - $bits(rob_request_t)){1'b0}}, req};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, req);
	endtask

	task automatic send_simple(logic [OP_W-1:0] op, int unsigned phys, bit flag, int unsigned idx);
		rob_request_t req;
		req.old_phys_reg = 6'(phys);
		req.old_reg_valid = flag;
		req.entry_index = 4'(idx);
		send_request(op, req);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic random_request(int unsigned alloc_w, int unsigned mark_w);
		int unsigned pick;
		logic [OP_W-1:0] op;
		rob_request_t req;
		req.old_phys_reg = 6'($urandom_range(0, 63));
		req.old_reg_valid = 1'($urandom_range(0, 1));
		req.entry_index = 4'($urandom_range(0, ROB_DEPTH - 1));
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			op = OP_UNUSED;
		end else if (pick < 2 + alloc_w) begin
			op = OP_ALLOC;
		end else if (pick < 2 + alloc_w + mark_w) begin
			op = OP_MARK;
			if (sb.live != 0 && $urandom_range(0, 4) != 0) begin
				if ($urandom_range(0, 1) == 1)
					req.entry_index = 4'(sb.head);
				else
					req.entry_index =
						4'((sb.head + $urandom_range(0, sb.live - 1)) % ROB_DEPTH);
			end
		end else begin
			op = OP_COMMIT;
		end
		send_request(op, req);
	endtask

	initial begin : stimulus
		int unsigned profile;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner cases on an empty buffer, then single entries, then a full buffer and a rejected allocate.
		send_simple(OP_COMMIT, 0, 1'b0, 0);
		send_simple(OP_UNUSED, 63, 1'b1, 15);
		send_simple(OP_ALLOC, 63, 1'b1, 0);
		send_simple(OP_COMMIT, 0, 1'b0, 0);
		send_simple(OP_MARK, 0, 1'b0, 0);
		send_simple(OP_COMMIT, 0, 1'b0, 0);
		send_simple(OP_ALLOC, 0, 1'b0, 15);
		send_simple(OP_MARK, 63, 1'b1, 1);
		send_simple(OP_COMMIT, 63, 1'b1, 1);
		// This entry is not live yet; the allocate that reaches it clears the mark.
		send_simple(OP_MARK, 0, 1'b0, 15);
		for (int i = 0; i < ROB_DEPTH; i++)
			send_simple(OP_ALLOC, $urandom_range(0, 63), 1'(i % 2), 0);
		send_simple(OP_ALLOC, 42, 1'b1, 0);
		send_simple(OP_COMMIT, 0, 1'b0, 0);
		wait_drained();

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			steady = ($urandom_range(0, 3) == 0);
			profile = $urandom_range(0, 2);
			if (b % 2 == 1)
				wait_drained();
			for (int i = 0; i < BLOCK_LEN; i++) begin
				case (profile)
				0: random_request(60, 20);
				1: random_request(10, 45);
				default: random_request(33, 33);
				endcase
			end
		end

		steady = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		$display("Ran %0d requests: %0d commits, %0d registers freed, %0d allocates rejected.",
			sb.requests, sb.commits, sb.frees, sb.rejects);
		if (sb.errors == 0)
			$display("in_order_reorder_buffer_core_test: clean");
		else
			$display("in_order_reorder_buffer_core_test: errors");
		$finish;
	end

endmodule
